// ===== design/subpix_pkg.sv =====
// Shared types, constants and helpers of the eight-tap subpixel row filter.
// Used by every module of the block; depends on nothing else.
package subpix_pkg;

  // Widths of the stream fields and of the coefficient registers.
  localparam int unsigned PixW     = 8;
  localparam int unsigned TapW     = 8;
  localparam int unsigned NumTaps  = 8;
  localparam int unsigned CfgIdxW  = $clog2(NumTaps);

  // Row fill counter: saturates once a full window of history is held.
  localparam int unsigned FillW    = 3;
  localparam logic [FillW-1:0] FillFull = FillW'(NumTaps - 1);

  // Arithmetic widths: one product, a pair of products, the rounded total.
  localparam int unsigned ProdW    = 16;
  localparam int unsigned PairW    = ProdW + 1;
  localparam int unsigned SumW     = ProdW + 4;

  // Right shift after rounding and the matching round-half-up constant.
  localparam int unsigned FilterShift = 7;
  localparam logic signed [SumW-1:0] RoundConst = SumW'(1) << (FilterShift - 1);

  // The centre tap resets to 127/128, just under unity gain; the others to zero.
  localparam int unsigned TapCentre      = 3;
  localparam int unsigned TapCentreReset = 127;

  typedef logic        [PixW-1:0]  pix_t;
  typedef logic signed [TapW-1:0]  tap_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [PairW-1:0] pair_t;

  // Load enables for one cell of the window chain.
  typedef struct packed {
    logic shift;  // take the neighbour's pixel (a request was accepted)
    logic mult;   // register the product of the held pixel and the tap
  } cell_ctl_t;

  // Load enables for the summation stages.
  typedef struct packed {
    logic ld_pair;
    logic ld_out;
  } sum_ctl_t;

  // Reset value of coefficient register k.
  function automatic tap_t tap_reset(int unsigned k);
    tap_t val;
    val = '0;
    if (k == TapCentre) begin
      val = TapW'(TapCentreReset);
    end
    return val;
  endfunction

endpackage

// ===== design/subpix_cell.sv =====
// One cell of the filter window: holds a pixel, passes it on along the row
// and registers its product with the cell's tap. Depends on subpix_pkg.
module subpix_cell
  import subpix_pkg::*;
(
  input  logic      clk_i,
  input  cell_ctl_t ctl_i,
  input  tap_t      tap_i,
  input  pix_t      pix_i,
  output pix_t      pix_o,
  output prod_t     prod_o
);

  localparam int unsigned MulW = ProdW + 1;

  pix_t                  pixel_q;
  prod_t                 prod_q;
  logic signed [MulW-1:0] mul_full;

  // Signed tap times unsigned pixel; the result always fits the product width.
  always_comb begin
    mul_full = MulW'(tap_i) * MulW'($signed({1'b0, pixel_q}));
  end

  // Pixel shifts in from the neighbour; the product is captured separately.
  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      pixel_q <= pix_i;
    end
    if (ctl_i.mult) begin
      prod_q <= mul_full[ProdW-1:0];
    end
  end

  assign pix_o  = pixel_q;
  assign prod_o = prod_q;

endmodule

// ===== design/subpix_sum.sv =====
// Summation of the eight cell products, rounding, shift and clip to a pixel.
// Two register stages; depends on subpix_pkg.
module subpix_sum
  import subpix_pkg::*;
(
  input  logic     clk_i,
  input  sum_ctl_t ctl_i,
  input  prod_t    prod_i [NumTaps],
  output pix_t     pix_o
);

  localparam int unsigned NumPairs = NumTaps / 2;

  pair_t                  pair_q [NumPairs];
  logic signed [SumW-1:0] total;
  logic signed [SumW-1:0] shifted;
  pix_t                   result;
  pix_t                   out_q;

  // First stage adds neighbouring products.
  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_pair) begin
      for (int k = 0; k < NumPairs; k++) begin
        pair_q[k] <= PairW'(prod_i[2*k]) + PairW'(prod_i[2*k+1]);
      end
    end
  end

  // Second stage: total with rounding, then shift and clip to 0..255.
  always_comb begin
    total = RoundConst;
    for (int k = 0; k < NumPairs; k++) begin
      total = total + SumW'(pair_q[k]);
    end
    shifted = total >>> FilterShift;
    if (total < 0) begin
      result = '0;
    end else if (shifted[SumW-1:PixW] != '0) begin
      result = '1;
    end else begin
      result = shifted[PixW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_out) begin
      out_q <= result;
    end
  end

  assign pix_o = out_q;

endmodule

// ===== design/eight_tap_subpixel_row_filter.sv =====
// Top level of the eight-tap subpixel row filter: window cell chain,
// coefficient registers, row fill count and pipeline control.
// Depends on subpix_pkg, subpix_cell and subpix_sum.
//
//   Channel   Direction  Signals                           Contents
//   s_axis    in         tvalid tready tdata[7:0] tuser    tdata: pixel_in; tuser: row_start
//   m_axis    out        tvalid tready tdata[7:0]          tdata: filtered_pixel
//   cfg       in         cfg_we_i cfg_idx_i cfg_wdata_i    taps 0..7, signed 8 bit
//
// One request is taken per clock until output back-pressure fills the pipeline. A
// result moves from the request that completes it through the window register,
// product register, pair sums and the output register, each one stage of the pipeline.
// Reset clears the pipeline, the row fill count and the taps (tap 3 to 127).
// Each stage moves on when the next one is empty or moving, so the input
// keeps flowing while a result waits, until the pipeline is full.
module eight_tap_subpixel_row_filter
  import subpix_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Pixel stream in.
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [PixW-1:0]    s_axis_tdata,   // [7:0] pixel_in
  input  logic               s_axis_tuser,   // [0] row_start
  // Filtered pixel stream out.
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [PixW-1:0]    m_axis_tdata,   // [7:0] filtered_pixel
  // Coefficient writes.
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [TapW-1:0]    cfg_wdata_i
);

  tap_t             taps_q [NumTaps];
  logic [FillW-1:0] fill_q, fill_d, fill_eff;
  logic             va_q, vb_q, vc_q, vd_q;
  logic             va_d, vb_d, vc_d, vd_d;
  logic             adv_a, adv_b, adv_c, adv_d;
  logic             accept, emit;
  cell_ctl_t        cell_ctl;
  sum_ctl_t         sum_ctl;
  pix_t             chain [NumTaps+1];
  prod_t            prod [NumTaps];
  pix_t             result;

  // Coefficient registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumTaps; k++) begin
        taps_q[k] <= tap_reset(k);
      end
    end else if (cfg_we_i) begin
      taps_q[cfg_idx_i] <= $signed(cfg_wdata_i);
    end
  end

  // Pipeline flow: a stage advances when the one after it is free.
  always_comb begin
    adv_d  = !vd_q || m_axis_tready;
    adv_c  = !vc_q || adv_d;
    adv_b  = !vb_q || adv_c;
    adv_a  = !va_q || adv_b;
    accept = s_axis_tvalid && adv_a;
  end

  // Row fill count: a row mark restarts it before the pixel is counted.
  always_comb begin
    fill_eff = s_axis_tuser ? '0 : fill_q;
    emit     = (fill_eff == FillFull);
    fill_d   = fill_q;
    if (accept) begin
      fill_d = emit ? FillFull : fill_eff + FillW'(1);
    end
  end

  // Valid bits follow the data through the stages.
  always_comb begin
    va_d = adv_a ? (accept && emit) : va_q;
    vb_d = adv_b ? va_q : vb_q;
    vc_d = adv_c ? vb_q : vc_q;
    vd_d = adv_d ? vc_q : vd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      va_q   <= 1'b0;
      vb_q   <= 1'b0;
      vc_q   <= 1'b0;
      vd_q   <= 1'b0;
    end else begin
      fill_q <= fill_d;
      va_q   <= va_d;
      vb_q   <= vb_d;
      vc_q   <= vc_d;
      vd_q   <= vd_d;
    end
  end

  // Window chain: the newest pixel enters the last cell and moves down.
  assign cell_ctl.shift = accept;
  assign cell_ctl.mult  = adv_b;
  assign chain[NumTaps] = s_axis_tdata;

  for (genvar k = 0; k < NumTaps; k++) begin : g_cell
    subpix_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (cell_ctl),
      .tap_i  (taps_q[k]),
      .pix_i  (chain[k+1]),
      .pix_o  (chain[k]),
      .prod_o (prod[k])
    );
  end

  // Summation, rounding and clipping.
  assign sum_ctl.ld_pair = adv_c;
  assign sum_ctl.ld_out  = adv_d;

  subpix_sum u_sum (
    .clk_i  (clk_i),
    .ctl_i  (sum_ctl),
    .prod_i (prod),
    .pix_o  (result)
  );

  assign s_axis_tready = adv_a;
  assign m_axis_tvalid = vd_q;
  assign m_axis_tdata  = result;

endmodule

// ===== design/subpix_checker.sv =====
// Port-level checks of the eight-tap subpixel row filter, bound to the top.
// Depends on subpix_pkg and the top-level port list.
module subpix_checker
  import subpix_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            s_axis_tvalid,
  input logic            s_axis_tready,
  input logic            m_axis_tvalid,
  input logic            m_axis_tready,
  input logic [PixW-1:0] m_axis_tdata
);

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or vanished");

  // An empty output register means the input side is never held off.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output is empty");

  // A draining sink never stalls the source.
  a_ready_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output is taken");

  // With no new requests and a ready sink throughout, the pipeline drains and the output goes empty.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!s_acc && m_axis_tready) ##1 (!s_acc && m_axis_tready) ##1
    (!s_acc && m_axis_tready) ##1 (!s_acc && m_axis_tready) |=> !m_axis_tvalid)
    else $error("pipeline did not drain");

endmodule

bind eight_tap_subpixel_row_filter subpix_checker u_subpix_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
